// File: design/cwsd_pkg.sv
// Shared constants, types and codes of the centered window sum decimator.
package cwsd_pkg;

    // Block sizing
    localparam int CHANNELS   = 8;
    localparam int MAX_WINDOW = 63;
    localparam int MAX_FRAMES = 65536;

    // Field widths
    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 38;
    localparam int CIDX_W     = 16;
    localparam int WS_W       = 6;
    localparam int FS_W       = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int CIDX_MAX   = (1 << CIDX_W) - 1;

    // Per-channel history ring of prefix sums
    localparam int RING_LEN    = 64;
    localparam int RING_AW     = 6;
    localparam int RING_DEPTH  = CHANNELS * RING_LEN;
    localparam int RING_ADDR_W = $clog2(RING_DEPTH);

    // Derived widths
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FRAME_W  = $clog2(MAX_FRAMES);
    localparam int FCNT_W   = $clog2(MAX_FRAMES + 1);

    // Largest usable odd window and its half width
    localparam int WIN_ODD     = ((MAX_WINDOW % 2) == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
    localparam int WIN_ODD_MAX = (WIN_ODD > 63) ? 63 : WIN_ODD;
    localparam int H_MAX       = WIN_ODD_MAX / 2;
    localparam int H_W         = (H_MAX > 0) ? $clog2(H_MAX + 1) : 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE = CFG_IDX_W'(0),
        REG_FRAME_SKIP  = CFG_IDX_W'(1)
    } cfg_reg_t;

    // Decoded configuration handed to the sequencer
    typedef struct packed {
        logic [H_W-1:0]  half;
        logic [FS_W-1:0] skip;
    } cfg_t;

    // Ring write and read requests
    typedef struct packed {
        logic                   en;
        logic [RING_ADDR_W-1:0] addr;
        logic [SUM_W-1:0]       data;
    } ring_wr_t;

    typedef struct packed {
        logic                   en;
        logic [RING_ADDR_W-1:0] addr;
    } ring_rd_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_NORM,
        ST_FREAD,
        ST_FEMIT
    } state_t;

endpackage

// File: design/cwsd_if.sv
// Valid/ready channel interfaces for samples in and window sums out.
interface cwsd_in_if;
    import cwsd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;

    modport source (output valid, channel, sample, last_sample, input ready);
    modport sink   (input valid, channel, sample, last_sample, output ready);
endinterface

interface cwsd_out_if;
    import cwsd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CH_W-1:0]         out_channel;
    logic [CIDX_W-1:0]       center_index;
    logic signed [SUM_W-1:0] window_sum;
    logic                    last_result;
    logic                    overflow;

    modport source (output valid, out_channel, center_index, window_sum, last_result,
                    overflow, input ready);
    modport sink   (input valid, out_channel, center_index, window_sum, last_result,
                    overflow, output ready);
endinterface

// File: design/cwsd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module cwsd_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/cwsd_ctrl.sv
// Sequencer: per-channel state, prefix-sum update, window differences and flush walk.
module cwsd_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    cwsd_in_if.sink                     samples,
    cwsd_out_if.source                  sums,
    input  cwsd_pkg::cfg_t              cfg,
    output cwsd_pkg::ring_wr_t          ring_wr,
    output cwsd_pkg::ring_rd_t          ring_rd,
    input  logic [cwsd_pkg::SUM_W-1:0]  ring_rdata
);
    import cwsd_pkg::*;

    // Ring address of a frame of a channel
    function automatic logic [RING_ADDR_W-1:0] ring_addr(input logic [CH_IDX_W-1:0] ch,
                                                         input logic [RING_AW-1:0] f);
        ring_addr = RING_ADDR_W'(ch) * RING_ADDR_W'(RING_LEN) + RING_ADDR_W'(f);
    endfunction

    state_t state_reg, state_next;

    // Per-channel state
    logic [FCNT_W-1:0] fc_reg    [CHANNELS];
    logic [SUM_W-1:0]  pre_reg   [CHANNELS];
    logic [FS_W-1:0]   phase_reg [CHANNELS];
    logic              ovf_reg   [CHANNELS];

    logic              chan_we;
    logic [FCNT_W-1:0] fc_cur, fc_next;
    logic [SUM_W-1:0]  pre_cur, pre_next;
    logic [FS_W-1:0]   ph_cur, ph_next;
    logic              ovf_cur, ovf_next;

    // Current item
    logic [CH_IDX_W-1:0]        ch_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       last_reg;
    logic [FRAME_W-1:0]         c_reg, c_next;
    logic [FRAME_W-1:0]         fstart_reg, fstart_next;
    logic [H_W-1:0]             cnt_reg, cnt_next;
    logic [H_W-1:0]             fcnt_reg, fcnt_next;
    logic                       sub_reg, sub_next;
    logic [SUM_W-1:0]           ptop_reg, ptop_next;

    // Output register
    logic                    ov_reg;
    logic [CH_W-1:0]         o_ch_reg;
    logic [CIDX_W-1:0]       o_cidx_reg;
    logic [SUM_W-1:0]        o_sum_reg;
    logic                    o_last_reg;
    logic                    o_ovf_reg;

    // Datapath terms
    logic                    accept, ch_ok;
    logic                    t_full, has_center, sub_u, sub_f;
    logic [FCNT_W-1:0]       h_f, two_h1, sub_frame;
    logic [FRAME_W-1:0]      tl_u, h_fr, fstart_u, fread_frame;
    logic [H_W-1:0]          fcnt_u, k_after;
    logic [SUM_W-1:0]        x_ext, pnew, win_sum;
    logic [FS_W:0]           ph_inc, fs_ext;
    logic [FS_W-1:0]         ph_step;
    logic                    produce, more, can_load, stall, load;
    logic [CIDX_W-1:0]       cidx;

    assign fc_cur  = fc_reg[ch_reg];
    assign pre_cur = pre_reg[ch_reg];
    assign ph_cur  = phase_reg[ch_reg];
    assign ovf_cur = ovf_reg[ch_reg];

    // Input handshake
    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign ch_ok         = 32'(samples.channel) < 32'(CHANNELS);

    // Frame bookkeeping for the newest sample
    assign h_f        = FCNT_W'(cfg.half);
    assign two_h1     = FCNT_W'({cfg.half, 1'b1});
    assign t_full     = (fc_cur == FCNT_W'(MAX_FRAMES));
    assign has_center = !t_full && (fc_cur >= h_f);
    assign sub_u      = (fc_cur >= two_h1);
    assign sub_frame  = fc_cur - two_h1;
    assign tl_u       = t_full ? FRAME_W'(MAX_FRAMES - 1) : FRAME_W'(fc_cur);
    assign x_ext      = {{(SUM_W - SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg};
    assign pnew       = pre_cur + x_ext;

    // Flush range: centers tl-h+1 .. tl, clipped at frame zero
    assign h_fr     = FRAME_W'(cfg.half);
    assign fstart_u = (tl_u >= h_fr) ? tl_u - h_fr + FRAME_W'(1) : '0;
    assign fcnt_u   = (tl_u >= h_fr) ? cfg.half : H_W'(tl_u) + H_W'(1);

    // Flush window start: subtract prefix at c-h-1 when the window is not clipped
    assign sub_f       = (c_reg > h_fr);
    assign fread_frame = c_reg - h_fr - FRAME_W'(1);

    // Window difference and center phase step
    assign win_sum = ptop_reg - (sub_reg ? ring_rdata : '0);
    assign fs_ext  = {1'b0, cfg.skip};
    assign ph_inc  = {1'b0, ph_cur} + (FS_W + 1)'(1);
    assign ph_step = (ph_inc >= fs_ext) ? '0 : ph_inc[FS_W-1:0];
    assign produce = (ph_cur == '0);
    assign k_after = (state_reg == ST_NORM) ? (last_reg ? fcnt_reg : '0)
                                            : cnt_reg - H_W'(1);
    // A later center yields a result if the phase reaches zero within k_after steps
    assign more     = (k_after != '0) &&
                      ((ph_step == '0) || ((FS_W + 1)'(k_after) > (fs_ext - {1'b0, ph_step})));
    assign can_load = !ov_reg || sums.ready;
    assign stall    = produce && !can_load;
    assign cidx     = (32'(c_reg) > 32'(CIDX_MAX)) ? CIDX_W'(CIDX_MAX) : CIDX_W'(c_reg);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, channel updates and ring requests
    always_comb
    begin
        state_next  = state_reg;
        chan_we     = 1'b0;
        fc_next     = fc_cur;
        pre_next    = pre_cur;
        ph_next     = ph_cur;
        ovf_next    = ovf_cur;
        c_next      = c_reg;
        fstart_next = fstart_reg;
        cnt_next    = cnt_reg;
        fcnt_next   = fcnt_reg;
        sub_next    = sub_reg;
        ptop_next   = ptop_reg;
        ring_wr     = '0;
        ring_rd     = '0;
        load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && ch_ok)
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                chan_we     = 1'b1;
                fstart_next = fstart_u;
                fcnt_next   = fcnt_u;
                if (t_full)
                begin
                    // Sample dropped past the frame limit
                    ovf_next  = 1'b1;
                    ptop_next = pre_cur;
                    if (!last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (fcnt_u == '0)
                    begin
                        fc_next    = '0;
                        pre_next   = '0;
                        ph_next    = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        c_next     = fstart_u;
                        cnt_next   = fcnt_u;
                        state_next = ST_FREAD;
                    end
                end
                else
                begin
                    // Store the new prefix sum and fetch the one before the window
                    ring_wr.en   = 1'b1;
                    ring_wr.addr = ring_addr(ch_reg, fc_cur[RING_AW-1:0]);
                    ring_wr.data = pnew;
                    fc_next      = fc_cur + FCNT_W'(1);
                    pre_next     = pnew;
                    ptop_next    = pnew;
                    if (has_center)
                    begin
                        c_next       = FRAME_W'(fc_cur - h_f);
                        sub_next     = sub_u;
                        ring_rd.en   = sub_u;
                        ring_rd.addr = ring_addr(ch_reg, sub_frame[RING_AW-1:0]);
                        state_next   = ST_NORM;
                    end
                    else if (last_reg)
                    begin
                        c_next     = fstart_u;
                        cnt_next   = fcnt_u;
                        state_next = ST_FREAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_NORM:
            begin
                load = produce && can_load;
                if (!stall)
                begin
                    chan_we = 1'b1;
                    ph_next = ph_step;
                    if (!last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (fcnt_reg == '0)
                    begin
                        fc_next    = '0;
                        pre_next   = '0;
                        ph_next    = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        c_next     = fstart_reg;
                        cnt_next   = fcnt_reg;
                        state_next = ST_FREAD;
                    end
                end
            end

            ST_FREAD:
            begin
                sub_next     = sub_f;
                ring_rd.en   = sub_f;
                ring_rd.addr = ring_addr(ch_reg, fread_frame[RING_AW-1:0]);
                state_next   = ST_FEMIT;
            end

            ST_FEMIT:
            begin
                load = produce && can_load;
                if (!stall)
                begin
                    chan_we  = 1'b1;
                    ph_next  = ph_step;
                    c_next   = c_reg + FRAME_W'(1);
                    cnt_next = cnt_reg - H_W'(1);
                    if (cnt_reg == H_W'(1))
                    begin
                        // End of sequence: clear the channel
                        fc_next    = '0;
                        pre_next   = '0;
                        ph_next    = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FREAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Per-channel state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                fc_reg[i]    <= '0;
                pre_reg[i]   <= '0;
                phase_reg[i] <= '0;
                ovf_reg[i]   <= 1'b0;
            end
            ov_reg <= 1'b0;
        end
        else
        begin
            if (chan_we)
            begin
                fc_reg[ch_reg]    <= fc_next;
                pre_reg[ch_reg]   <= pre_next;
                phase_reg[ch_reg] <= ph_next;
                ovf_reg[ch_reg]   <= ovf_next;
            end
            if (load)
            begin
                ov_reg <= 1'b1;
            end
            else if (sums.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg   <= CH_IDX_W'(samples.channel);
            x_reg    <= samples.sample;
            last_reg <= samples.last_sample;
        end
        c_reg      <= c_next;
        fstart_reg <= fstart_next;
        cnt_reg    <= cnt_next;
        fcnt_reg   <= fcnt_next;
        sub_reg    <= sub_next;
        ptop_reg   <= ptop_next;
        if (load)
        begin
            o_ch_reg   <= CH_W'(ch_reg);
            o_cidx_reg <= cidx;
            o_sum_reg  <= win_sum;
            o_last_reg <= !more;
            o_ovf_reg  <= ovf_cur;
        end
    end

    assign sums.valid        = ov_reg;
    assign sums.out_channel  = o_ch_reg;
    assign sums.center_index = o_cidx_reg;
    assign sums.window_sum   = o_sum_reg;
    assign sums.last_result  = o_last_reg;
    assign sums.overflow     = o_ovf_reg;

endmodule

// File: design/centered_window_sum_decimator.sv
// Top level: configuration registers, sequencer and prefix-sum ring memory.
//
//  port       dir  kind        payload
//  samples    in   valid/ready channel, sample, last_sample
//  sums       out  valid/ready out_channel, center_index, window_sum, last_result, overflow
//  cfg_*      in   write only  window_size (index 0), frame_skip (index 1)
//
// A sample passes ST_IDLE and ST_UPDATE, and ST_NORM too when it completes a window; a
// last_sample adds ST_FREAD and ST_FEMIT per flushed window (up to window_size/2).
// Reset clears the per-channel counters, sums and phases; the ring needs no clearing.
// A full output register stalls the sequencer only when it has a result to place.
module centered_window_sum_decimator (
    input  logic                               clk,
    input  logic                               rst_n,
    cwsd_in_if.sink                            samples,
    cwsd_out_if.source                         sums,
    input  logic                               cfg_we,
    input  logic [cwsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cwsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cwsd_pkg::*;

    logic [WS_W-1:0] ws_reg;
    logic [FS_W-1:0] fs_reg;
    logic [WS_W-1:0] w_odd;
    logic [7:0]      w_clip;
    cfg_t            cfg;
    ring_wr_t        ring_wr;
    ring_rd_t        ring_rd;
    logic [SUM_W-1:0] ring_rdata;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg <= WS_W'(1);
            fs_reg <= FS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WINDOW_SIZE: ws_reg <= cfg_data[WS_W-1:0];
                REG_FRAME_SKIP:  fs_reg <= cfg_data[FS_W-1:0];
                default:         ;
            endcase
        end
    end

    // Odd window, clipped, and its half; zero skip acts as one
    assign w_odd    = ws_reg | WS_W'(1);
    assign w_clip   = (8'(w_odd) > 8'(WIN_ODD_MAX)) ? 8'(WIN_ODD_MAX) : 8'(w_odd);
    assign cfg.half = H_W'(w_clip >> 1);
    assign cfg.skip = (fs_reg == '0) ? FS_W'(1) : fs_reg;

    cwsd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .sums       (sums),
        .cfg        (cfg),
        .ring_wr    (ring_wr),
        .ring_rd    (ring_rd),
        .ring_rdata (ring_rdata)
    );

    cwsd_ram #(
        .WIDTH (SUM_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_wr.en),
        .waddr (ring_wr.addr),
        .wdata (ring_wr.data),
        .re    (ring_rd.en),
        .raddr (ring_rd.addr),
        .rdata (ring_rdata)
    );

endmodule

// File: design/cwsd_checker.sv
// Port-level checker for the decimator and its bind to the top level.
module cwsd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [cwsd_pkg::CH_W-1:0]     s_channel,
    input logic                          r_valid,
    input logic                          r_ready,
    input logic [cwsd_pkg::CH_W-1:0]     r_out_channel,
    input logic [cwsd_pkg::CIDX_W-1:0]   r_center_index,
    input logic [cwsd_pkg::SUM_W-1:0]    r_window_sum,
    input logic                          r_last_result,
    input logic                          r_overflow
);
    import cwsd_pkg::*;

    // Stalled result keeps valid and payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid &&
            $stable({r_out_channel, r_center_index, r_window_sum, r_last_result, r_overflow}))
        else $error("result changed while stalled");

    // A taken sample of a valid channel leaves the sequencer busy in the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready && (32'(s_channel) < 32'(CHANNELS)) |=> !s_ready)
        else $error("sample input ready right after a transfer");

    // Results are placed only while a sample is being worked on
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(r_valid) |-> !$past(s_ready))
        else $error("result appeared while the sequencer was idle");

    // Result channel is a configured channel
    a_out_channel: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (32'(r_out_channel) < 32'(CHANNELS)))
        else $error("result for a channel out of range");

endmodule

bind centered_window_sum_decimator cwsd_checker u_cwsd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .s_valid        (samples.valid),
    .s_ready        (samples.ready),
    .s_channel      (samples.channel),
    .r_valid        (sums.valid),
    .r_ready        (sums.ready),
    .r_out_channel  (sums.out_channel),
    .r_center_index (sums.center_index),
    .r_window_sum   (sums.window_sum),
    .r_last_result  (sums.last_result),
    .r_overflow     (sums.overflow)
);
